FILE: hdl/tru_pkg.sv
// Package: request codes, operation classes, back-end states and the command record.
`timescale 1ns / 1ps

package tru_pkg;

  // Port widths fixed by the request and result formats
  localparam int TYPE_W  = 3;
  localparam int IDX_W   = 4;
  localparam int VALUE_W = 64;
  localparam int COUNT_W = 6;

  // Request codes as they arrive on req_type
  localparam logic [TYPE_W-1:0] REQ_READ  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_WRITE = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_INC   = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_DEC   = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_ANDC  = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_ORC   = 3'd5;

  // Trit codes
  localparam logic [1:0] TRIT_F = 2'b00;
  localparam logic [1:0] TRIT_U = 2'b01;
  localparam logic [1:0] TRIT_T = 2'b11;

  // Operation class chosen by the front end
  typedef enum logic [2:0] {
    OP_READ,
    OP_WRITE,
    OP_INC,
    OP_DEC,
    OP_AND_CNT,
    OP_OR_CNT,
    OP_BAD
  } op_t;

  // Back-end sequencer states
  typedef enum logic {
    BK_READ,
    BK_EXEC
  } back_state_t;

  // Classified request held in the command queue
  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  reg_a;
    logic [IDX_W-1:0]  reg_b;
    logic [VALUE_W-1:0] wdata;
  } cmd_t;

endpackage

FILE: hdl/tru_front.sv
// Front end: classifies a request and screens its register indexes.
`timescale 1ns / 1ps

module tru_front #(
  parameter int NUM_REGS = 16
) (
  input  logic [tru_pkg::TYPE_W-1:0]  req_type,
  input  logic [tru_pkg::IDX_W-1:0]   reg_a,
  input  logic [tru_pkg::IDX_W-1:0]   reg_b,
  input  logic [tru_pkg::VALUE_W-1:0] write_trits,
  output tru_pkg::cmd_t               cmd
);

  logic bad_a;
  logic bad_b;
  tru_pkg::op_t op;

  // Index range checks
  assign bad_a = {3'b000, reg_a} >= 7'(NUM_REGS);
  assign bad_b = {3'b000, reg_b} >= 7'(NUM_REGS);

  // Decode; unused codes behave as a read
  always_comb begin
    case (req_type)
      tru_pkg::REQ_WRITE: op = tru_pkg::OP_WRITE;
      tru_pkg::REQ_INC:   op = tru_pkg::OP_INC;
      tru_pkg::REQ_DEC:   op = tru_pkg::OP_DEC;
      tru_pkg::REQ_ANDC:  op = bad_b ? tru_pkg::OP_BAD : tru_pkg::OP_AND_CNT;
      tru_pkg::REQ_ORC:   op = bad_b ? tru_pkg::OP_BAD : tru_pkg::OP_OR_CNT;
      default:            op = tru_pkg::OP_READ;
    endcase
    if (bad_a) begin
      op = tru_pkg::OP_BAD;
    end
  end

  assign cmd.op    = op;
  assign cmd.reg_a = reg_a;
  assign cmd.reg_b = reg_b;
  assign cmd.wdata = write_trits;

endmodule

FILE: hdl/tru_cmdq.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module tru_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tru_pkg::cmd_t push_cmd,
  input  logic          pop,
  output tru_pkg::cmd_t head_cmd,
  output logic          full,
  output logic          empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  tru_pkg::cmd_t      slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     fill;

  assign full     = fill == (PTR_W + 1)'(DEPTH);
  assign empty    = fill == '0;
  assign head_cmd = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: hdl/tru_back.sv
// Back end: trit register file, increment/decrement and count units, result stages.
`timescale 1ns / 1ps

module tru_back #(
  parameter int NUM_REGS      = 16,
  parameter int TRITS_PER_REG = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  tru_pkg::cmd_t               q_head,
  output logic                        q_pop,
  output logic                        done,
  output logic [tru_pkg::VALUE_W-1:0] reg_value,
  output logic [tru_pkg::COUNT_W-1:0] true_count
);

  localparam int T   = TRITS_PER_REG;
  localparam int W   = 2 * TRITS_PER_REG;
  localparam int AW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int NG  = (TRITS_PER_REG + 7) / 8;
  localparam logic [W-1:0] RESET_VAL = {TRITS_PER_REG{tru_pkg::TRIT_U}};

  // Register file with per-entry valid bits; invalid entries read as all U
  logic [W-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;

  tru_pkg::back_state_t state, state_next;

  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic [W-1:0]  rd_a;
  logic [W-1:0]  rd_b;
  logic          rv_a;
  logic          rv_b;

  tru_pkg::op_t  ex_op;
  logic [AW-1:0] ex_addr;
  logic [W-1:0]  ex_wdata;

  logic [W-1:0]  a_val;
  logic [W-1:0]  b_val;
  logic [T-1:0]  a_is_t;
  logic [T-1:0]  a_is_f;
  logic [T-1:0]  b_is_t;
  logic [T:0]    inc_sum;
  logic [T:0]    dec_sum;
  logic [T-1:0]  inc_ch;
  logic [T-1:0]  dec_ch;
  logic [W-1:0]  inc_val;
  logic [W-1:0]  dec_val;
  logic [W-1:0]  new_val;
  logic          wr_en;
  logic [T-1:0]  hit;
  logic [NG*8-1:0] hit_pad;
  logic [3:0]    part [NG];

  logic          s1_valid;
  logic [W-1:0]  s1_val;
  logic [3:0]    s1_part [NG];
  logic [tru_pkg::COUNT_W-1:0] cnt_sum;

  assign rd_addr_a = AW'({3'b000, q_head.reg_a});
  assign rd_addr_b = AW'({3'b000, q_head.reg_b});

  // Sequencer: read the file, then execute and write back
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tru_pkg::BK_READ;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      tru_pkg::BK_READ: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = tru_pkg::BK_EXEC;
        end
      end
      tru_pkg::BK_EXEC: begin
        state_next = tru_pkg::BK_READ;
      end
      default: begin
        state_next = tru_pkg::BK_READ;
      end
    endcase
  end

  // Registered file reads and command capture
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_a     <= mem[rd_addr_a];
      rd_b     <= mem[rd_addr_b];
      rv_a     <= vld[rd_addr_a];
      rv_b     <= vld[rd_addr_b];
      ex_op    <= q_head.op;
      ex_addr  <= rd_addr_a;
      ex_wdata <= q_head.wdata[W-1:0];
    end
  end

  assign a_val = rv_a ? rd_a : RESET_VAL;
  assign b_val = rv_b ? rd_b : RESET_VAL;

  // Trit classes
  always_comb begin
    for (int i = 0; i < T; i++) begin
      a_is_t[i] = a_val[2*i +: 2] == tru_pkg::TRIT_T;
      a_is_f[i] = a_val[2*i +: 2] == tru_pkg::TRIT_F;
      b_is_t[i] = b_val[2*i +: 2] == tru_pkg::TRIT_T;
    end
  end

  // Ripple reach: all trits up to and including the first that absorbs the carry
  assign inc_sum = {1'b0, a_is_t} + (T + 1)'(1);
  assign dec_sum = {1'b0, a_is_f} + (T + 1)'(1);
  assign inc_ch  = inc_sum[T-1:0] ^ a_is_t;
  assign dec_ch  = dec_sum[T-1:0] ^ a_is_f;

  always_comb begin
    inc_val = a_val;
    dec_val = a_val;
    for (int i = 0; i < T; i++) begin
      if (inc_ch[i]) begin
        if (a_is_t[i]) begin
          inc_val[2*i +: 2] = tru_pkg::TRIT_F;
        end else if (a_is_f[i]) begin
          inc_val[2*i +: 2] = tru_pkg::TRIT_U;
        end else begin
          inc_val[2*i +: 2] = tru_pkg::TRIT_T;
        end
      end
      if (dec_ch[i]) begin
        if (a_is_f[i]) begin
          dec_val[2*i +: 2] = tru_pkg::TRIT_T;
        end else if (a_is_t[i]) begin
          dec_val[2*i +: 2] = tru_pkg::TRIT_U;
        end else begin
          dec_val[2*i +: 2] = tru_pkg::TRIT_F;
        end
      end
    end
  end

  // Result value and write enable
  always_comb begin
    wr_en   = 1'b0;
    new_val = a_val;
    case (ex_op)
      tru_pkg::OP_WRITE: begin
        new_val = ex_wdata;
        wr_en   = 1'b1;
      end
      tru_pkg::OP_INC: begin
        new_val = inc_val;
        wr_en   = 1'b1;
      end
      tru_pkg::OP_DEC: begin
        new_val = dec_val;
        wr_en   = 1'b1;
      end
      tru_pkg::OP_BAD: begin
        new_val = '0;
      end
      default: begin
        new_val = a_val;
      end
    endcase
    if (state != tru_pkg::BK_EXEC) begin
      wr_en = 1'b0;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ex_addr] <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[ex_addr] <= 1'b1;
    end
  end

  // Count: per-position match, then partial sums over groups of eight
  always_comb begin
    case (ex_op)
      tru_pkg::OP_AND_CNT: hit = a_is_t & b_is_t;
      tru_pkg::OP_OR_CNT:  hit = a_is_t | b_is_t;
      default:             hit = '0;
    endcase
  end

  assign hit_pad = (NG * 8)'(hit);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part[g] = '0;
      for (int k = 0; k < 8; k++) begin
        part[g] = part[g] + 4'(hit_pad[g*8 + k]);
      end
    end
  end

  // Stage one: value and partial counts
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= state == tru_pkg::BK_EXEC;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tru_pkg::BK_EXEC) begin
      s1_val  <= new_val;
      s1_part <= part;
    end
  end

  // Stage two: final count and result registers
  always_comb begin
    cnt_sum = '0;
    for (int g = 0; g < NG; g++) begin
      cnt_sum = cnt_sum + tru_pkg::COUNT_W'(s1_part[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      reg_value  <= tru_pkg::VALUE_W'(s1_val);
      true_count <= cnt_sum;
    end
  end

endmodule

FILE: hdl/ternary_register_unit.sv
// Top level: balanced-ternary register file unit with decoupled front and back ends.
// Path: a request passes the queue, the registered file read, stage one and the done register.
// The back end reads the file, then executes and writes back, before it takes the next request.
// A 2-entry command queue takes requests while the back end works; busy is high when it is full.
// Results are shown for one cycle on done; the receiver cannot stall them.
// Reset: synchronous; empties the queue and marks all registers as all-U, with no clearing pass.
`timescale 1ns / 1ps

module ternary_register_unit #(
  parameter int NUM_REGS      = 16,
  parameter int TRITS_PER_REG = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [tru_pkg::TYPE_W-1:0]  req_type,
  input  logic [tru_pkg::IDX_W-1:0]   reg_a,
  input  logic [tru_pkg::IDX_W-1:0]   reg_b,
  input  logic [tru_pkg::VALUE_W-1:0] write_trits,
  output logic                        done,
  output logic [tru_pkg::VALUE_W-1:0] reg_value,
  output logic [tru_pkg::COUNT_W-1:0] true_count
);

  tru_pkg::cmd_t front_cmd;
  tru_pkg::cmd_t head_cmd;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          push;

  assign busy = q_full;
  assign push = start && !q_full;

  tru_front #(
    .NUM_REGS (NUM_REGS)
  ) u_front (
    .req_type    (req_type),
    .reg_a       (reg_a),
    .reg_b       (reg_b),
    .write_trits (write_trits),
    .cmd         (front_cmd)
  );

  tru_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  tru_back #(
    .NUM_REGS      (NUM_REGS),
    .TRITS_PER_REG (TRITS_PER_REG)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (head_cmd),
    .q_pop      (q_pop),
    .done       (done),
    .reg_value  (reg_value),
    .true_count (true_count)
  );

endmodule

FILE: hdl/tru_checker.sv
// Port checker for the ternary register unit, bound to the top level.
`timescale 1ns / 1ps

module tru_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [tru_pkg::COUNT_W-1:0] true_count
);

  // Requests taken but not yet answered
  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({start && !busy, done})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  // No result without an outstanding request
  a_no_orphan: assert property (@(posedge clk) disable iff (rst) done |-> pending != 3'd0)
    else $error("result without outstanding request");

  // Back end never issues two results back to back
  a_spacing: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("results on consecutive cycles");

  // Reset leaves nothing in flight
  a_reset: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("activity right after reset");

  // A count never exceeds the register width
  a_count: assert property (@(posedge clk) disable iff (rst) done |-> true_count <= 6'd32)
    else $error("count out of range");

endmodule

bind ternary_register_unit tru_checker u_tru_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .true_count (true_count)
);
